// ===== rtl/gait_sequence_stepper_top_macros.svh =====
// ----------------------------------------------------------------------------
// Gait sequence stepper assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef GAIT_SEQUENCE_STEPPER_TOP_MACROS_SVH
`define GAIT_SEQUENCE_STEPPER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define GSS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define GSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gss_pkg.sv =====
// ----------------------------------------------------------------------------
// gss_pkg
// Types, codes and helpers shared by the gait sequence stepper modules.
// ----------------------------------------------------------------------------
package gss_pkg;

   localparam int MAX_STEPS = 256;

   localparam int ID_W    = 5;
   localparam int IDX_W   = 8;
   localparam int TOT_W   = 9;
   localparam int DIST_W  = 16;
   localparam int PHASE_W = 3;
   localparam int STAGE_W = 2;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 16;

   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_MOVE   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_NEXT   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CHANGE = 3'd4;

   localparam logic [STAGE_W-1:0] ST_PREPARE  = 2'd0;
   localparam logic [STAGE_W-1:0] ST_MAIN     = 2'd1;
   localparam logic [STAGE_W-1:0] ST_FINALIZE = 2'd2;

   localparam logic [ID_W-1:0] ID_NONE         = 5'd0;
   localparam logic [ID_W-1:0] ID_UP           = 5'd1;
   localparam logic [ID_W-1:0] ID_DOWN         = 5'd2;
   localparam logic [ID_W-1:0] ID_FORWARD      = 5'd4;
   localparam logic [ID_W-1:0] ID_FORWARD_SLOW = 5'd8;
   localparam logic [ID_W-1:0] ID_LAST         = 5'd16;

   localparam logic [CSR_A_W-1:0] CSR_DIST_LIMIT  = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_DOWN_MAIN   = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_DOWN_FIN    = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_DOWN_TOTAL  = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_DOWN_LOOPED = 3'd4;

   typedef struct packed {
      logic             looped;
      logic [TOT_W-1:0] total;
      logic [IDX_W-1:0] fin_b;
      logic [IDX_W-1:0] main_b;
   } desc_type;

   localparam desc_type DESC_ZERO       = '0;
   localparam desc_type DOWN_DESC_RESET = '{looped: 1'b0, total: 9'd1,
                                            fin_b: 8'd0, main_b: 8'd0};

   typedef struct packed {
      logic              func;
      logic [ID_W-1:0]   seq_id;
      desc_type          desc;
      logic              move_done;
      logic [DIST_W-1:0] clearance;
      logic              engine_disabled;
   } item_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance_limit;
      desc_type          down_desc;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               internal_error;
      logic               request_accepted;
      logic               body_up;
      logic [ID_W-1:0]    pending_sequence;
      logic [ID_W-1:0]    active_sequence;
      logic [IDX_W-1:0]   step_index;
      logic               start_move;
   } result_type;

   function automatic logic [TOT_W-1:0] clamp_total(input logic [TOT_W-1:0] t);
      return (t > TOT_W'(MAX_STEPS)) ? TOT_W'(MAX_STEPS) : t;
   endfunction

endpackage

// ===== rtl/gss_core.sv =====
// ----------------------------------------------------------------------------
// gss_core
// Sequence state and the one-pass next-state logic for select and tick items.
// ----------------------------------------------------------------------------
module gss_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  gss_pkg::item_type   item,
   input  gss_pkg::cfg_type    cfg,
   output gss_pkg::result_type result
);

   logic [gss_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [gss_pkg::STAGE_W-1:0] stage_ff, stage_in;
   logic [gss_pkg::TOT_W-1:0]   count_ff, count_in;
   logic [gss_pkg::ID_W-1:0]    cur_id_ff, cur_id_in;
   logic [gss_pkg::ID_W-1:0]    nxt_id_ff, nxt_id_in;
   gss_pkg::desc_type           cur_desc_ff, cur_desc_in;
   gss_pkg::desc_type           nxt_desc_ff, nxt_desc_in;
   logic                        body_ff, body_in;

   gss_pkg::desc_type           down_desc;
   gss_pkg::desc_type           req_desc;
   logic                        sel_ok;
   logic                        start;
   logic                        accepted;
   logic                        id_error;

   always_comb begin
      down_desc       = cfg.down_desc;
      down_desc.total = gss_pkg::clamp_total(cfg.down_desc.total);
      req_desc        = item.desc;
      req_desc.total  = gss_pkg::clamp_total(item.desc.total);
   end

   always_comb begin
      if (item.seq_id == gss_pkg::ID_NONE) begin
         sel_ok = 1'b1;
      end else if (item.seq_id == gss_pkg::ID_UP) begin
         sel_ok = !body_ff;
      end else if (item.seq_id == gss_pkg::ID_FORWARD ||
                   item.seq_id == gss_pkg::ID_FORWARD_SLOW) begin
         sel_ok = body_ff && (item.clearance >= cfg.distance_limit);
      end else begin
         sel_ok = body_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      stage_in    = stage_ff;
      count_in    = count_ff;
      cur_id_in   = cur_id_ff;
      nxt_id_in   = nxt_id_ff;
      cur_desc_in = cur_desc_ff;
      nxt_desc_in = nxt_desc_ff;
      body_in     = body_ff;
      start       = 1'b0;
      accepted    = 1'b0;
      id_error    = 1'b0;

      if (item.func) begin
         if (item.seq_id > gss_pkg::ID_LAST) begin
            id_error = 1'b1;
         end else if (sel_ok) begin
            accepted  = 1'b1;
            nxt_id_in = item.seq_id;
            if (item.seq_id == gss_pkg::ID_NONE) begin
               nxt_desc_in = gss_pkg::DESC_ZERO;
            end else if (item.seq_id == gss_pkg::ID_DOWN) begin
               nxt_desc_in = down_desc;
            end else begin
               nxt_desc_in = req_desc;
            end
         end
      end else if (!item.engine_disabled) begin
         unique case (phase_ff)
            gss_pkg::PH_IDLE: begin
               if (cur_id_ff != nxt_id_ff) begin
                  phase_in = gss_pkg::PH_CHANGE;
               end
            end
            gss_pkg::PH_MOVE: begin
               start    = 1'b1;
               phase_in = gss_pkg::PH_WAIT;
            end
            gss_pkg::PH_WAIT: begin
               if (item.move_done) begin
                  phase_in = gss_pkg::PH_NEXT;
               end
            end
            gss_pkg::PH_NEXT: begin
               count_in = count_ff + 9'd1;
               phase_in = gss_pkg::PH_MOVE;
               if (stage_in == gss_pkg::ST_PREPARE &&
                   count_in >= {1'b0, cur_desc_ff.main_b}) begin
                  stage_in = gss_pkg::ST_MAIN;
               end
               if (stage_in == gss_pkg::ST_MAIN &&
                   count_in >= {1'b0, cur_desc_ff.fin_b}) begin
                  if (cur_id_ff != nxt_id_ff) begin
                     count_in = {1'b0, cur_desc_ff.fin_b};
                     stage_in = gss_pkg::ST_FINALIZE;
                  end else if (cur_desc_ff.looped) begin
                     count_in = {1'b0, cur_desc_ff.main_b};
                  end else begin
                     body_in     = (cur_id_ff != gss_pkg::ID_DOWN);
                     nxt_id_in   = gss_pkg::ID_NONE;
                     nxt_desc_in = gss_pkg::DESC_ZERO;
                     phase_in    = gss_pkg::PH_CHANGE;
                  end
               end
               if (stage_in == gss_pkg::ST_FINALIZE && count_in >= cur_desc_ff.total) begin
                  phase_in = gss_pkg::PH_CHANGE;
               end
            end
            gss_pkg::PH_CHANGE: begin
               cur_id_in   = nxt_id_ff;
               cur_desc_in = (nxt_id_ff == gss_pkg::ID_DOWN) ? down_desc : nxt_desc_ff;
               count_in    = '0;
               stage_in    = gss_pkg::ST_PREPARE;
               phase_in    = (nxt_id_ff == gss_pkg::ID_NONE) ? gss_pkg::PH_IDLE
                                                            : gss_pkg::PH_MOVE;
            end
            default: begin
               phase_in = gss_pkg::PH_IDLE;
            end
         endcase
         if ((cur_id_in == gss_pkg::ID_FORWARD || cur_id_in == gss_pkg::ID_FORWARD_SLOW) &&
             item.clearance < cfg.distance_limit) begin
            nxt_id_in   = gss_pkg::ID_NONE;
            nxt_desc_in = gss_pkg::DESC_ZERO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= gss_pkg::PH_IDLE;
         stage_ff    <= gss_pkg::ST_PREPARE;
         count_ff    <= '0;
         cur_id_ff   <= gss_pkg::ID_NONE;
         nxt_id_ff   <= gss_pkg::ID_DOWN;
         cur_desc_ff <= gss_pkg::DESC_ZERO;
         nxt_desc_ff <= gss_pkg::DOWN_DESC_RESET;
         body_ff     <= 1'b0;
      end else if (item_valid) begin
         phase_ff    <= phase_in;
         stage_ff    <= stage_in;
         count_ff    <= count_in;
         cur_id_ff   <= cur_id_in;
         nxt_id_ff   <= nxt_id_in;
         cur_desc_ff <= cur_desc_in;
         nxt_desc_ff <= nxt_desc_in;
         body_ff     <= body_in;
      end
   end

   always_comb begin
      result.start_move       = start;
      result.step_index       = count_in[gss_pkg::IDX_W-1:0];
      result.active_sequence  = cur_id_in;
      result.pending_sequence = nxt_id_in;
      result.body_up          = body_in;
      result.request_accepted = accepted;
      result.internal_error   = id_error;
      result.phase            = phase_in;
   end

endmodule

// ===== rtl/gait_sequence_stepper_top.sv =====
// ----------------------------------------------------------------------------
// gait_sequence_stepper_top
// Motion sequence stepper: select requests and phase ticks in, status out.
// ----------------------------------------------------------------------------
// One request is taken per clock when the response side keeps up. A request
// is registered on entry, the sequence state and the response are computed
// from it once the skid entry is empty, and the response sits in an output
// register. A one-entry skid buffer behind the output register takes a
// response while rsp_tready stalls; req_tready drops while the skid entry is
// held and a request waits, so a stall on rsp_tready that outlasts the skid
// entry holds off requests. CSR writes take effect on the next clock and are
// meant for an idle block.
module gait_sequence_stepper_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [4:0] seq_id, [12:5] main_begin, [20:13] finalize_begin, [29:21] total_steps,
   // [30] loops, [31] move_done, [47:32] clearance, [48] engine_disabled,
   // [55:49] zero
   input  logic [55:0]                  req_tdata,
   // [0] func
   input  logic                         req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] start_move, [8:1] step_index, [13:9] active_sequence,
   // [18:14] pending_sequence, [19] body_up, [20] request_accepted,
   // [21] internal_error, [24:22] phase, [31:25] zero
   output logic [31:0]                  rsp_tdata,
   input  logic                         csr_we,
   input  logic [gss_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [gss_pkg::CSR_D_W-1:0]  csr_wdata
);

   `include "gait_sequence_stepper_top_macros.svh"

   gss_pkg::cfg_type    cfg_ff, cfg_in;
   gss_pkg::item_type   item_ff, item_in;
   logic                item_valid_ff, item_valid_in;
   gss_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   gss_pkg::result_type skid_ff, skid_in;
   logic                skid_valid_ff, skid_valid_in;
   gss_pkg::result_type result;
   logic                adv;
   logic                pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            gss_pkg::CSR_DIST_LIMIT:  cfg_in.distance_limit   = csr_wdata;
            gss_pkg::CSR_DOWN_MAIN:   cfg_in.down_desc.main_b = csr_wdata[7:0];
            gss_pkg::CSR_DOWN_FIN:    cfg_in.down_desc.fin_b  = csr_wdata[7:0];
            gss_pkg::CSR_DOWN_TOTAL:  cfg_in.down_desc.total  = csr_wdata[8:0];
            gss_pkg::CSR_DOWN_LOOPED: cfg_in.down_desc.looped = csr_wdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   assign adv        = item_valid_ff && !skid_valid_ff;
   assign req_tready = !item_valid_ff || adv;
   assign pop        = out_valid_ff && rsp_tready;

   always_comb begin
      item_in                 = item_ff;
      item_valid_in           = item_valid_ff && !adv;
      if (req_tvalid && req_tready) begin
         item_valid_in                = 1'b1;
         item_in.func                 = req_tuser;
         item_in.seq_id               = req_tdata[4:0];
         item_in.desc.main_b          = req_tdata[12:5];
         item_in.desc.fin_b           = req_tdata[20:13];
         item_in.desc.total           = req_tdata[29:21];
         item_in.desc.looped          = req_tdata[30];
         item_in.move_done            = req_tdata[31];
         item_in.clearance            = req_tdata[47:32];
         item_in.engine_disabled      = req_tdata[48];
      end
   end

   gss_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (adv),
      .item       (item_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = adv;
         end
      end else if (adv) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.distance_limit <= '0;
         cfg_ff.down_desc      <= gss_pkg::DOWN_DESC_RESET;
         item_valid_ff         <= 1'b0;
         out_valid_ff          <= 1'b0;
         skid_valid_ff         <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_ff};

   `GSS_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid entry held while output register empty")
   `GSS_ASSERT_NEXT(a_adv_gives_rsp, clock, reset, adv, out_valid_ff,
      "processed request produced no response")
   `GSS_ASSERT_SAME(a_start_in_wait, clock, reset, adv && result.start_move,
      result.phase == gss_pkg::PH_WAIT && !item_ff.func,
      "start pulse outside a move tick")
   `GSS_ASSERT_SAME(a_err_not_accepted, clock, reset, adv && result.internal_error,
      !result.request_accepted,
      "invalid id request was accepted")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Gait sequence stepper testbench
// Drives tick and select requests into gait_sequence_stepper_top with random
// gaps and response stalls. A local copy of the sequencer state machine
// predicts every response, and each response is checked field by field in
// order. A short directed run covers refusals, invalid ids, the down
// descriptor, oversized totals and forward cancellation. Random phases follow
// under several register settings, from all-minimum to all-maximum.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gss_pkg::*;

   localparam int CYCLE_LIMIT = 250000;

   typedef enum logic [1:0] {SEL_REFUSED, SEL_TAKEN, SEL_INVALID} select_outcome_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [55:0]         req_tdata;
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [31:0]         rsp_tdata;
   logic                csr_we;
   logic [CSR_A_W-1:0]  csr_addr;
   logic [CSR_D_W-1:0]  csr_wdata;

   // sequencer copy
   logic [PHASE_W-1:0]  seq_phase;
   logic [STAGE_W-1:0]  seq_stage;
   logic [TOT_W-1:0]    step_count;
   logic [ID_W-1:0]     active_id;
   logic [ID_W-1:0]     queued_id;
   desc_type            active_desc;
   desc_type            queued_desc;
   logic                body_raised;
   logic [DIST_W-1:0]   guard_distance;
   desc_type            down_setting;

   result_type          status_due[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  send_rush = 1'b0;
   bit                  take_rush = 1'b0;
   bit                  rsp_taken = 1'b0;
   int                  stall_left = 0;

   gait_sequence_stepper_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic desc_type make_desc(input logic [7:0] mb, input logic [7:0] fb,
                                          input logic [8:0] tot, input logic lp);
      desc_type d;
      d.main_b = mb;
      d.fin_b  = fb;
      d.total  = tot;
      d.looped = lp;
      return d;
   endfunction

   function automatic logic [TOT_W-1:0] limit_total(input logic [TOT_W-1:0] t);
      return (t > 9'd256) ? 9'd256 : t;
   endfunction

   function automatic desc_type down_descriptor();
      desc_type d;
      d = down_setting;
      d.total = limit_total(d.total);
      return d;
   endfunction

   function automatic select_outcome_type choose_sequence(input logic [ID_W-1:0] id,
                                                          input desc_type d,
                                                          input logic [DIST_W-1:0] front);
      logic ok;
      if (id > ID_LAST) return SEL_INVALID;
      if (id == ID_NONE) ok = 1'b1;
      else if (id == ID_UP) ok = !body_raised;
      else if (id == ID_FORWARD || id == ID_FORWARD_SLOW)
         ok = body_raised && (front >= guard_distance);
      else ok = body_raised;
      if (!ok) return SEL_REFUSED;
      queued_id = id;
      if (id == ID_NONE) queued_desc = DESC_ZERO;
      else if (id == ID_DOWN) queued_desc = down_descriptor();
      else queued_desc = d;
      return SEL_TAKEN;
   endfunction

   function automatic logic advance_phase(input logic move_done,
                                          input logic [DIST_W-1:0] front);
      logic start;
      start = 1'b0;
      case (seq_phase)
         PH_IDLE: begin
            if (active_id != queued_id) seq_phase = PH_CHANGE;
         end
         PH_MOVE: begin
            start = 1'b1;
            seq_phase = PH_WAIT;
         end
         PH_WAIT: begin
            if (move_done) seq_phase = PH_NEXT;
         end
         PH_NEXT: begin
            step_count = step_count + 9'd1;
            seq_phase = PH_MOVE;
            if (seq_stage == ST_PREPARE && step_count >= active_desc.main_b)
               seq_stage = ST_MAIN;
            if (seq_stage == ST_MAIN && step_count >= active_desc.fin_b) begin
               if (active_id != queued_id) begin
                  step_count = 9'(active_desc.fin_b);
                  seq_stage = ST_FINALIZE;
               end else if (active_desc.looped) begin
                  step_count = 9'(active_desc.main_b);
               end else begin
                  body_raised = (active_id != ID_DOWN);
                  void'(choose_sequence(ID_NONE, DESC_ZERO, front));
                  seq_phase = PH_CHANGE;
               end
            end
            if (seq_stage == ST_FINALIZE && step_count >= active_desc.total)
               seq_phase = PH_CHANGE;
         end
         PH_CHANGE: begin
            active_id = queued_id;
            active_desc = (queued_id == ID_DOWN) ? down_descriptor() : queued_desc;
            step_count = '0;
            seq_stage = ST_PREPARE;
            seq_phase = (active_id == ID_NONE) ? PH_IDLE : PH_MOVE;
         end
         default: begin
            seq_phase = PH_IDLE;
         end
      endcase
      // forward motion is dropped while something is too close
      if ((active_id == ID_FORWARD || active_id == ID_FORWARD_SLOW) &&
          front < guard_distance)
         void'(choose_sequence(ID_NONE, DESC_ZERO, front));
      return start;
   endfunction

   function automatic result_type predict_status(input item_type it);
      result_type r;
      desc_type d;
      select_outcome_type outcome;
      r = '0;
      if (it.func) begin
         d = it.desc;
         d.total = limit_total(d.total);
         outcome = choose_sequence(it.seq_id, d, it.clearance);
         r.request_accepted = (outcome == SEL_TAKEN);
         r.internal_error = (outcome == SEL_INVALID);
      end else if (!it.engine_disabled) begin
         r.start_move = advance_phase(it.move_done, it.clearance);
      end
      r.step_index = step_count[7:0];
      r.active_sequence = active_id;
      r.pending_sequence = queued_id;
      r.body_up = body_raised;
      r.phase = seq_phase;
      return r;
   endfunction

   task automatic send_request(input item_type it);
      int gap;
      gap = send_rush ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 39) == 0) send_rush = !send_rush;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= it.func;
      req_tdata <= {7'd0, it.engine_disabled, it.clearance, it.move_done,
                    it.desc.looped, it.desc.total, it.desc.fin_b, it.desc.main_b,
                    it.seq_id};
      do @(posedge clock); while (!req_tready);
      status_due.push_back(predict_status(it));
   endtask

   task automatic release_request();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic send_tick(input logic md, input logic [15:0] front, input logic dis);
      item_type it;
      it = '0;
      it.func = 1'b0;
      it.move_done = md;
      it.clearance = front;
      it.engine_disabled = dis;
      send_request(it);
   endtask

   task automatic send_select(input logic [ID_W-1:0] id, input desc_type d,
                              input logic [15:0] front);
      item_type it;
      it = '0;
      it.func = 1'b1;
      it.seq_id = id;
      it.desc = d;
      it.clearance = front;
      send_request(it);
   endtask

   task automatic program_registers(input logic [15:0] limit, input desc_type down);
      release_request();
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= CSR_DIST_LIMIT;
      csr_wdata <= limit;
      @(negedge clock);
      csr_addr <= CSR_DOWN_MAIN;
      csr_wdata <= 16'(down.main_b);
      @(negedge clock);
      csr_addr <= CSR_DOWN_FIN;
      csr_wdata <= 16'(down.fin_b);
      @(negedge clock);
      csr_addr <= CSR_DOWN_TOTAL;
      csr_wdata <= 16'(down.total);
      @(negedge clock);
      csr_addr <= CSR_DOWN_LOOPED;
      csr_wdata <= 16'(down.looped);
      @(negedge clock);
      csr_we <= 1'b0;
      guard_distance = limit;
      down_setting = down;
   endtask

   task automatic random_request();
      logic [63:0] raw;
      item_type it;
      int pick;
      int f;
      logic [7:0] mb;
      logic [7:0] fb;
      raw = {$urandom(), $urandom()};
      it = raw[$bits(item_type)-1:0];
      if ($urandom_range(0, 99) < 70) begin
         it.func = 1'b0;
         it.engine_disabled = ($urandom_range(0, 19) == 0);
         it.move_done = ($urandom_range(0, 4) != 0);
      end else begin
         it.func = 1'b1;
         pick = $urandom_range(0, 99);
         if (!body_raised && pick < 45) it.seq_id = ID_UP;
         else if (pick < 8) it.seq_id = 5'($urandom_range(17, 31));
         else if (pick < 18) it.seq_id = ID_NONE;
         else if (pick < 30) it.seq_id = ID_DOWN;
         else if (pick < 45) it.seq_id = $urandom_range(0, 1) ? ID_FORWARD : ID_FORWARD_SLOW;
         else it.seq_id = 5'($urandom_range(1, 16));
         // mostly short ordered descriptors, a few unordered or full range
         pick = $urandom_range(0, 99);
         if (pick < 87) begin
            mb = 8'($urandom_range(0, 3));
            fb = mb + 8'($urandom_range(0, 4));
            it.desc = make_desc(mb, fb, 9'(fb) + 9'($urandom_range(0, 4)),
                                1'($urandom_range(0, 1)));
         end else if (pick < 97) begin
            it.desc = make_desc(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                                9'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 2) != 0) begin
         f = int'(guard_distance) + int'($urandom_range(0, 2)) - 1;
         if (f < 0) f = 0;
         if (f > 65535) f = 65535;
         it.clearance = 16'(f);
      end
      send_request(it);
   endtask

   task automatic run_random_phase(input logic [15:0] limit, input desc_type down,
                                   input int count);
      program_registers(limit, down);
      repeat (count) random_request();
   endtask

   task automatic test_power_up_sequences();
      send_tick(1'b1, 16'd0, 1'b1);
      send_select(5'd31, make_desc(8'hFF, 8'hFF, 9'h1FF, 1'b1), 16'hFFFF);
      send_select(5'd17, DESC_ZERO, 16'd0);
      send_select(5'd5, make_desc(8'd0, 8'd1, 9'd2, 1'b0), 16'd100);
      send_select(ID_DOWN, make_desc(8'hFF, 8'hFF, 9'h1FF, 1'b1), 16'd0);
      repeat (6) send_tick(1'b1, 16'd0, 1'b0);
      send_select(ID_UP, make_desc(8'd0, 8'd1, 9'd300, 1'b0), 16'd0);
      repeat (6) send_tick(1'b1, 16'hFFFF, 1'b0);
   endtask

   task automatic test_forward_guard();
      program_registers(16'd1000, make_desc(8'd1, 8'd2, 9'd3, 1'b0));
      send_select(ID_FORWARD, make_desc(8'd0, 8'd1, 9'd2, 1'b1), 16'd999);
      send_select(ID_FORWARD_SLOW, make_desc(8'd0, 8'd1, 9'd2, 1'b1), 16'd1000);
      send_tick(1'b1, 16'hFFFF, 1'b0);
      send_tick(1'b1, 16'hFFFF, 1'b0);
      send_tick(1'b1, 16'd1000, 1'b0);
      send_tick(1'b0, 16'd0, 1'b0);
      send_tick(1'b1, 16'd2000, 1'b0);
      send_tick(1'b1, 16'd2000, 1'b0);
      send_tick(1'b1, 16'd2000, 1'b0);
   endtask

   task automatic test_minimum_settings();
      run_random_phase(16'd0, make_desc(8'd0, 8'd0, 9'd0, 1'b0), 190);
   endtask

   task automatic test_random_settings();
      logic [15:0] limit;
      logic [7:0] mb;
      logic [7:0] fb;
      repeat (4) begin
         limit = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3000));
         mb = 8'($urandom_range(0, 3));
         fb = mb + 8'($urandom_range(0, 4));
         run_random_phase(limit, make_desc(mb, fb, 9'(fb) + 9'($urandom_range(0, 4)),
                                           1'($urandom_range(0, 1))), 190);
      end
   endtask

   task automatic test_maximum_settings();
      run_random_phase(16'hFFFF, make_desc(8'hFF, 8'hFF, 9'h1FF, 1'b1), 190);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_taken = 1'b1;
         seen = rsp_tdata[24:0];
         if (status_due.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = status_due.pop_front();
            check_field("start_move", want.start_move, seen.start_move);
            check_field("step_index", want.step_index, seen.step_index);
            check_field("active_sequence", want.active_sequence, seen.active_sequence);
            check_field("pending_sequence", want.pending_sequence, seen.pending_sequence);
            check_field("body_up", want.body_up, seen.body_up);
            check_field("request_accepted", want.request_accepted, seen.request_accepted);
            check_field("internal_error", want.internal_error, seen.internal_error);
            check_field("phase", want.phase, seen.phase);
            check_field("padding", 0, rsp_tdata[31:25]);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            stall_left = take_rush ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 39) == 0) take_rush = !take_rush;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      guard_distance = '0;
      down_setting = DOWN_DESC_RESET;
      seq_phase = PH_IDLE;
      seq_stage = ST_PREPARE;
      step_count = '0;
      active_id = ID_NONE;
      queued_id = ID_DOWN;
      active_desc = DESC_ZERO;
      queued_desc = down_descriptor();
      body_raised = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_power_up_sequences();
      test_forward_guard();
      test_minimum_settings();
      test_random_settings();
      test_maximum_settings();

      release_request();
      while (status_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
